### sv/gpcb_pkg.sv
package gpcb_pkg;

   localparam int unsigned CsrIndexWidth = 3;
   localparam int unsigned CsrDataWidth  = 16;

   localparam logic [CsrIndexWidth-1:0] RegGaussAmplitude = 3'd0;
   localparam logic [CsrIndexWidth-1:0] RegGaussCenter    = 3'd1;
   localparam logic [CsrIndexWidth-1:0] RegGaussWidth     = 3'd2;
   localparam logic [CsrIndexWidth-1:0] RegCbAmplitude    = 3'd3;
   localparam logic [CsrIndexWidth-1:0] RegCbCenter       = 3'd4;
   localparam logic [CsrIndexWidth-1:0] RegCbWidth        = 3'd5;
   localparam logic [CsrIndexWidth-1:0] RegCbTailStart    = 3'd6;
   localparam logic [CsrIndexWidth-1:0] RegCbTailPower    = 3'd7;

   typedef struct packed {
      logic [15:0]        gauss_amplitude;
      logic signed [15:0] gauss_center;
      logic [14:0]        gauss_width;
      logic [15:0]        cb_amplitude;
      logic signed [15:0] cb_center;
      logic [14:0]        cb_width;
      logic signed [15:0] cb_tail_start;
      logic [14:0]        cb_tail_power;
   } cfg_type;

   localparam cfg_type CfgReset = '{
      gauss_amplitude: 16'd624,
      gauss_center:    16'sd5816,
      gauss_width:     15'd901,
      cb_amplitude:    16'd2752,
      cb_center:       16'sd10265,
      cb_width:        15'd573,
      cb_tail_start:   16'sd2621,
      cb_tail_power:   15'd6963
   };

   localparam logic [29:0] Ln2Q30    = 30'd744261118;
   localparam logic [16:0] Log2eQ16  = 17'd94548;
   localparam logic [30:0] Q30One    = 31'h4000_0000;
   localparam logic [31:0] CoreLimit = 32'd786432;
   localparam logic [22:0] OutMax    = 23'h7F_FFFF;

   // Floor of 2^32 / d for the small constant divisors used by the series.
   function automatic logic [32:0] recip(input logic [3:0] d);
      logic [32:0] m;
      case (d)
         4'd1:    m = 33'h1_0000_0000;
         4'd2:    m = 33'd2147483648;
         4'd3:    m = 33'd1431655765;
         4'd4:    m = 33'd1073741824;
         4'd5:    m = 33'd858993459;
         4'd6:    m = 33'd715827882;
         4'd7:    m = 33'd613566756;
         4'd8:    m = 33'd536870912;
         4'd9:    m = 33'd477218588;
         4'd11:   m = 33'd390451572;
         default: m = '0;
      endcase
      return m;
   endfunction

endpackage

### sv/gpcb_pipe.sv
module gpcb_pipe (
   input  logic                clock,
   input  logic                reset,
   input  logic                advance,
   input  logic                in_valid,
   input  logic signed [15:0]  in_x,
   input  gpcb_pkg::cfg_type   cfg,
   output logic                out_valid,
   output logic [22:0]         out_value
);

   localparam int PipeDepth = 94;

   typedef struct packed {
      logic [22:0] u_g;
      logic        zero_g;
      logic [22:0] u_c;
      logic        zero_c;
      logic        tail;
   } lane_type;

   typedef struct packed {
      logic [14:0] rem_g;
      logic [31:0] num_g;
      logic [14:0] rem_c;
      logic [31:0] num_c;
      logic        neg_c;
   } dist_type;

   typedef struct packed {
      logic [14:0] rem;
      logic [47:0] num;
      lane_type    lane;
   } zdiv_type;

   typedef struct packed {
      logic [47:0] m;
      logic [4:0]  lzc;
      lane_type    lane;
   } norm_type;

   typedef struct packed {
      logic [31:0] rem;
      logic [31:0] dv;
      logic [29:0] num;
      logic [4:0]  lzc;
      lane_type    lane;
   } qdiv_type;

   typedef struct packed {
      logic [29:0] pw;
      logic [29:0] q2;
      logic [29:0] q0;
      logic [31:0] sum;
      logic [4:0]  lzc;
      lane_type    lane;
   } ser_type;

   typedef struct packed {
      logic [35:0] lnv;
      lane_type    lane;
   } lnv_type;

   typedef struct packed {
      logic        zero;
      logic [25:0] u;
   } arg_type;

   typedef struct packed {
      logic        zero;
      logic [22:0] w;
   } wexp_type;

   typedef struct packed {
      logic        zero;
      logic [4:0]  k;
      logic [29:0] y;
      logic [30:0] r;
      logic [29:0] v;
      logic [29:0] q0;
   } exp_type;

   function automatic logic [46:0] dist_step(input logic [14:0] rem_i,
                                             input logic [31:0] num_i,
                                             input logic [14:0] dv);
      logic [15:0] t;
      logic [14:0] rem;
      logic [31:0] num;
      rem = rem_i;
      num = num_i;
      for (int i = 0; i < 4; i++) begin
         t   = {rem, num[31]};
         num = {num[30:0], 1'b0};
         if (t >= {1'b0, dv}) begin
            t      = t - {1'b0, dv};
            num[0] = 1'b1;
         end
         rem = t[14:0];
      end
      return {rem, num};
   endfunction

   function automatic logic [62:0] zdiv_step(input logic [14:0] rem_i,
                                             input logic [47:0] num_i,
                                             input logic [14:0] dv);
      logic [15:0] t;
      logic [14:0] rem;
      logic [47:0] num;
      rem = rem_i;
      num = num_i;
      for (int i = 0; i < 4; i++) begin
         t   = {rem, num[47]};
         num = {num[46:0], 1'b0};
         if (t >= {1'b0, dv}) begin
            t      = t - {1'b0, dv};
            num[0] = 1'b1;
         end
         rem = t[14:0];
      end
      return {rem, num};
   endfunction

   function automatic logic [61:0] qdiv_step(input logic [31:0] rem_i,
                                             input logic [29:0] num_i,
                                             input logic [31:0] dv);
      logic [32:0] t;
      logic [31:0] rem;
      logic [29:0] num;
      rem = rem_i;
      num = num_i;
      for (int i = 0; i < 2; i++) begin
         t   = {rem, 1'b0};
         num = {num[28:0], 1'b0};
         if (t >= {1'b0, dv}) begin
            t      = t - {1'b0, dv};
            num[0] = 1'b1;
         end
         rem = t[31:0];
      end
      return {rem, num};
   endfunction

   logic [14:0] sig_g;
   logic [14:0] sig_c;
   logic [14:0] n_eff;
   logic        alpha_neg;
   logic [15:0] a_abs;
   logic [15:0] a_mag;
   logic [19:0] a16;
   logic [31:0] a_sq;
   logic [22:0] a_sq_term;

   always_comb begin
      sig_g     = (cfg.gauss_width == '0) ? 15'd1 : cfg.gauss_width;
      sig_c     = (cfg.cb_width == '0) ? 15'd1 : cfg.cb_width;
      n_eff     = (cfg.cb_tail_power == '0) ? 15'd1 : cfg.cb_tail_power;
      alpha_neg = cfg.cb_tail_start[15];
      a_abs     = alpha_neg ? (16'd0 - cfg.cb_tail_start) : cfg.cb_tail_start;
      a_mag     = (a_abs == '0) ? 16'd1 : a_abs;
      a16       = {a_mag, 4'd0};
      a_sq      = 32'(a_mag) * 32'(a_mag);
      a_sq_term = a_sq[31:9];
   end

   logic [PipeDepth-1:0] vld_ff;
   logic [PipeDepth-1:0] vld_in;

   dist_type dist_in [0:8];
   dist_type dist_ff [0:8];
   zdiv_type zdiv_in [0:12];
   zdiv_type zdiv_ff [0:12];
   norm_type norm_in [0:5];
   norm_type norm_ff [0:5];
   qdiv_type qdiv_in [0:15];
   qdiv_type qdiv_ff [0:15];
   ser_type  ser_in  [0:5];
   ser_type  ser_ff  [0:5];
   ser_type  sa_in   [0:4];
   ser_type  sa_ff   [0:4];
   ser_type  sb_in   [0:4];
   ser_type  sb_ff   [0:4];
   lnv_type  lnv_in;
   lnv_type  lnv_ff;
   arg_type  arg_in  [0:1];
   arg_type  arg_ff  [0:1];
   wexp_type wexp_in [0:1];
   wexp_type wexp_ff [0:1];
   exp_type  xr_in   [0:1][0:9];
   exp_type  xr_ff   [0:1][0:9];
   exp_type  xa_in   [0:1][0:8];
   exp_type  xa_ff   [0:1][0:8];
   exp_type  xb_in   [0:1][0:8];
   exp_type  xb_ff   [0:1][0:8];
   logic [30:0] xo_in [0:1];
   logic [30:0] xo_ff [0:1];
   logic [46:0] pr_in [0:1];
   logic [46:0] pr_ff [0:1];
   logic [22:0] out_in;
   logic [22:0] out_ff;

   logic [16:0] diff_g;
   logic [16:0] diff_c;
   logic [16:0] ndiff_g;
   logic [16:0] ndiff_c;

   always_comb begin
      diff_g  = {in_x[15], in_x} - {cfg.gauss_center[15], cfg.gauss_center};
      diff_c  = {in_x[15], in_x} - {cfg.cb_center[15], cfg.cb_center};
      ndiff_g = 17'd0 - diff_g;
      ndiff_c = 17'd0 - diff_c;
      dist_in[0].rem_g = '0;
      dist_in[0].num_g = {(diff_g[16] ? ndiff_g[15:0] : diff_g[15:0]), 16'd0};
      dist_in[0].rem_c = '0;
      dist_in[0].num_c = {(diff_c[16] ? ndiff_c[15:0] : diff_c[15:0]), 16'd0};
      dist_in[0].neg_c = diff_c[16];
      for (int j = 0; j < 8; j++) begin
         {dist_in[j+1].rem_g, dist_in[j+1].num_g} =
            dist_step(dist_ff[j].rem_g, dist_ff[j].num_g, sig_g);
         {dist_in[j+1].rem_c, dist_in[j+1].num_c} =
            dist_step(dist_ff[j].rem_c, dist_ff[j].num_c, sig_c);
         dist_in[j+1].neg_c = dist_ff[j].neg_c;
      end
   end

   logic [31:0] tg;
   logic [31:0] tc;
   logic [39:0] sq_g;
   logic [39:0] sq_c;
   logic [31:0] s_c;

   always_comb begin
      tg   = dist_ff[8].num_g;
      tc   = dist_ff[8].num_c;
      sq_g = 40'(tg[19:0]) * 40'(tg[19:0]);
      sq_c = 40'(tc[19:0]) * 40'(tc[19:0]);
      s_c  = tc - 32'(a16);
      zdiv_in[0].rem         = '0;
      zdiv_in[0].num         = 48'(a_mag) * 48'(s_c);
      zdiv_in[0].lane.u_g    = sq_g[39:17];
      zdiv_in[0].lane.zero_g = (tg >= gpcb_pkg::CoreLimit);
      zdiv_in[0].lane.u_c    = sq_c[39:17];
      zdiv_in[0].lane.zero_c = (tc >= gpcb_pkg::CoreLimit);
      zdiv_in[0].lane.tail   = (dist_ff[8].neg_c ^ alpha_neg) && (tc > 32'(a16));
      for (int j = 0; j < 12; j++) begin
         {zdiv_in[j+1].rem, zdiv_in[j+1].num} =
            zdiv_step(zdiv_ff[j].rem, zdiv_ff[j].num, n_eff);
         zdiv_in[j+1].lane = zdiv_ff[j].lane;
      end
   end

   logic [4:0] sh;

   always_comb begin
      norm_in[0].m    = zdiv_ff[12].num + 48'h1_0000;
      norm_in[0].lzc  = '0;
      norm_in[0].lane = zdiv_ff[12].lane;
      sh = '0;
      for (int j = 0; j < 5; j++) begin
         sh = 5'(16 >> j);
         norm_in[j+1] = norm_ff[j];
         if ((norm_ff[j].m >> (6'd48 - 6'(sh))) == 48'd0) begin
            norm_in[j+1].m   = norm_ff[j].m << sh;
            norm_in[j+1].lzc = norm_ff[j].lzc + sh;
         end
      end
   end

   always_comb begin
      qdiv_in[0].rem  = {2'b00, norm_ff[5].m[46:17]};
      qdiv_in[0].dv   = 32'(norm_ff[5].m[47:17]) + 32'h4000_0000;
      qdiv_in[0].num  = '0;
      qdiv_in[0].lzc  = norm_ff[5].lzc;
      qdiv_in[0].lane = norm_ff[5].lane;
      for (int j = 0; j < 15; j++) begin
         qdiv_in[j+1] = qdiv_ff[j];
         {qdiv_in[j+1].rem, qdiv_in[j+1].num} =
            qdiv_step(qdiv_ff[j].rem, qdiv_ff[j].num, qdiv_ff[j].dv);
      end
   end

   logic [59:0] qq;
   logic [59:0] spp;
   logic [62:0] sqp;
   logic [33:0] srm;
   logic [29:0] sqv;
   logic [3:0]  kd;

   always_comb begin
      qq = 60'(qdiv_ff[15].num) * 60'(qdiv_ff[15].num);
      ser_in[0].pw   = qdiv_ff[15].num;
      ser_in[0].q2   = qq[59:30];
      ser_in[0].q0   = '0;
      ser_in[0].sum  = 32'(qdiv_ff[15].num);
      ser_in[0].lzc  = qdiv_ff[15].lzc;
      ser_in[0].lane = qdiv_ff[15].lane;
      spp = '0;
      sqp = '0;
      srm = '0;
      sqv = '0;
      kd  = '0;
      for (int j = 0; j < 5; j++) begin
         kd = 4'(3 + 2 * j);
         spp = 60'(ser_ff[j].pw) * 60'(ser_ff[j].q2);
         sa_in[j]    = ser_ff[j];
         sa_in[j].pw = spp[59:30];
         sqp = 63'(sa_ff[j].pw) * 63'(gpcb_pkg::recip(kd));
         sb_in[j]    = sa_ff[j];
         sb_in[j].q0 = sqp[61:32];
         srm = 34'(sb_ff[j].pw) - 34'(sb_ff[j].q0) * 34'(kd);
         sqv = sb_ff[j].q0 + 30'(srm >= 34'(kd));
         ser_in[j+1]     = sb_ff[j];
         ser_in[j+1].sum = sb_ff[j].sum + 32'(sqv);
      end
   end

   logic [4:0]  pm16;
   logic [50:0] np;
   logic [25:0] u_t;

   always_comb begin
      pm16 = 5'd31 - ser_ff[5].lzc;
      lnv_in.lnv  = 36'(35'(pm16) * 35'(gpcb_pkg::Ln2Q30)) + 36'({ser_ff[5].sum, 1'b0});
      lnv_in.lane = ser_ff[5].lane;
      np  = 51'(n_eff) * 51'(lnv_ff.lnv);
      u_t = 26'(a_sq_term) + 26'(np[50:26]);
      arg_in[0].zero = lnv_ff.lane.zero_g;
      arg_in[0].u    = 26'(lnv_ff.lane.u_g);
      if (lnv_ff.lane.tail) begin
         arg_in[1].zero = 1'b0;
         arg_in[1].u    = u_t;
      end else begin
         arg_in[1].zero = lnv_ff.lane.zero_c;
         arg_in[1].u    = 26'(lnv_ff.lane.u_c);
      end
   end

   logic [38:0] wp;
   logic [45:0] yp;
   logic [6:0]  k7;
   logic [60:0] vp;
   logic [62:0] xqp;
   logic [33:0] xrm;
   logic [29:0] xqv;
   logic [3:0]  dv;

   always_comb begin
      wp  = '0;
      yp  = '0;
      k7  = '0;
      vp  = '0;
      xqp = '0;
      xrm = '0;
      xqv = '0;
      dv  = '0;
      for (int l = 0; l < 2; l++) begin
         wp = 39'(arg_ff[l].u[21:0]) * 39'(gpcb_pkg::Log2eQ16);
         wexp_in[l].zero = arg_ff[l].zero | (arg_ff[l].u[25:22] != 4'd0);
         wexp_in[l].w    = wp[38:16];
         k7 = wexp_ff[l].w[22:16];
         yp = 46'(wexp_ff[l].w[15:0]) * 46'(gpcb_pkg::Ln2Q30);
         xr_in[l][0].zero = wexp_ff[l].zero | (k7 > 7'd30);
         xr_in[l][0].k    = k7[4:0];
         xr_in[l][0].y    = yp[45:16];
         xr_in[l][0].r    = gpcb_pkg::Q30One;
         xr_in[l][0].v    = '0;
         xr_in[l][0].q0   = '0;
         for (int j = 0; j < 9; j++) begin
            dv = 4'(9 - j);
            vp = 61'(xr_ff[l][j].y) * 61'(xr_ff[l][j].r);
            xa_in[l][j]   = xr_ff[l][j];
            xa_in[l][j].v = vp[59:30];
            xqp = 63'(xa_ff[l][j].v) * 63'(gpcb_pkg::recip(dv));
            xb_in[l][j]    = xa_ff[l][j];
            xb_in[l][j].q0 = xqp[61:32];
            xrm = 34'(xb_ff[l][j].v) - 34'(xb_ff[l][j].q0) * 34'(dv);
            xqv = xb_ff[l][j].q0 + 30'(xrm >= 34'(dv));
            xr_in[l][j+1]   = xb_ff[l][j];
            xr_in[l][j+1].r = gpcb_pkg::Q30One - 31'(xqv);
         end
         xo_in[l] = xr_ff[l][9].zero ? 31'd0 : (xr_ff[l][9].r >> xr_ff[l][9].k);
      end
   end

   logic [47:0] tot;

   always_comb begin
      pr_in[0] = 47'(cfg.gauss_amplitude) * 47'(xo_ff[0]);
      pr_in[1] = 47'(cfg.cb_amplitude) * 47'(xo_ff[1]);
      tot      = 48'(pr_ff[0]) + 48'(pr_ff[1]);
      out_in   = (tot[47:24] > {1'b0, gpcb_pkg::OutMax}) ? gpcb_pkg::OutMax : tot[46:24];
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         dist_ff <= dist_in;
         zdiv_ff <= zdiv_in;
         norm_ff <= norm_in;
         qdiv_ff <= qdiv_in;
         ser_ff  <= ser_in;
         sa_ff   <= sa_in;
         sb_ff   <= sb_in;
         lnv_ff  <= lnv_in;
         arg_ff  <= arg_in;
         wexp_ff <= wexp_in;
         xr_ff   <= xr_in;
         xa_ff   <= xa_in;
         xb_ff   <= xb_in;
         xo_ff   <= xo_in;
         pr_ff   <= pr_in;
         out_ff  <= out_in;
      end
   end

   assign vld_in = {vld_ff[PipeDepth-2:0], in_valid};

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (advance) begin
         vld_ff <= vld_in;
      end
   end

   assign out_valid = vld_ff[PipeDepth-1];
   assign out_value = out_ff;

endmodule

### sv/gauss_plus_crystal_ball_eval_core.sv
// Evaluates the sum of a scaled Gaussian peak and a scaled Crystal Ball peak at one Q4.12
// abscissa per word and returns an unsigned Q13.10 value that saturates at the top. A new
// word may be accepted in every cycle in which the result side is not stalled; the pipeline
// depth is set by the bit-serial dividers, the normalising shifter and the step-by-step
// exponential and logarithm series. A stalled result freezes the whole pipeline, so nothing
// is lost or repeated. The user must write the registers through the csr port only while no
// word is in flight; the block itself does not enforce this.
module gauss_plus_crystal_ball_eval_core (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_stall,
   input  logic signed [15:0]                     req_x_value,
   output logic                                   rsp_valid,
   input  logic                                   rsp_stall,
   output logic [22:0]                            rsp_curve_value,
   input  logic                                   csr_write_enable,
   input  logic [gpcb_pkg::CsrIndexWidth-1:0]     csr_index,
   input  logic [gpcb_pkg::CsrDataWidth-1:0]      csr_write_data
);

   gpcb_pkg::cfg_type cfg_ff;
   gpcb_pkg::cfg_type cfg_in;
   logic              rsp_valid_ff;
   logic              rsp_valid_in;
   logic [22:0]       rsp_value_ff;
   logic [22:0]       rsp_value_in;
   logic              advance;
   logic              pipe_valid;
   logic [22:0]       pipe_value;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_enable) begin
         case (csr_index)
            gpcb_pkg::RegGaussAmplitude: cfg_in.gauss_amplitude = csr_write_data;
            gpcb_pkg::RegGaussCenter:    cfg_in.gauss_center    = csr_write_data;
            gpcb_pkg::RegGaussWidth:     cfg_in.gauss_width     = csr_write_data[14:0];
            gpcb_pkg::RegCbAmplitude:    cfg_in.cb_amplitude    = csr_write_data;
            gpcb_pkg::RegCbCenter:       cfg_in.cb_center       = csr_write_data;
            gpcb_pkg::RegCbWidth:        cfg_in.cb_width        = csr_write_data[14:0];
            gpcb_pkg::RegCbTailStart:    cfg_in.cb_tail_start   = csr_write_data;
            gpcb_pkg::RegCbTailPower:    cfg_in.cb_tail_power   = csr_write_data[14:0];
            default:                     cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= gpcb_pkg::CfgReset;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign advance   = !rsp_valid_ff || !rsp_stall;
   assign req_stall = !advance;

   gpcb_pipe u_pipe (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .in_valid  (req_valid),
      .in_x      (req_x_value),
      .cfg       (cfg_ff),
      .out_valid (pipe_valid),
      .out_value (pipe_value)
   );

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_value_in = rsp_value_ff;
      if (advance) begin
         rsp_valid_in = pipe_valid;
         rsp_value_in = pipe_value;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_value_ff <= rsp_value_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_curve_value = rsp_value_ff;

endmodule

### test/tb_gauss_plus_crystal_ball_eval_core.sv
module tb_gauss_plus_crystal_ball_eval_core;

   localparam int unsigned CycleLimit = 600000;
   localparam int unsigned DrainCycles = 200;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic signed [15:0] req_x_value = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic [22:0] rsp_curve_value;
   logic csr_write_enable = 1'b0;
   logic [gpcb_pkg::CsrIndexWidth-1:0] csr_index = '0;
   logic [gpcb_pkg::CsrDataWidth-1:0] csr_write_data = '0;

   gpcb_pkg::cfg_type model_cfg = gpcb_pkg::CfgReset;
   logic signed [15:0] x_backlog[$];
   logic [22:0] expected_curve[$];
   int unsigned send_idle_pct = 0;
   int unsigned recv_stall_pct = 0;
   int unsigned mismatch_count = 0;
   int unsigned cycle_count = 0;

   gauss_plus_crystal_ball_eval_core dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_x_value(req_x_value),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_curve_value(rsp_curve_value),
      .csr_write_enable(csr_write_enable),
      .csr_index(csr_index),
      .csr_write_data(csr_write_data)
   );

   initial begin
      forever #2 clock = ~clock;
   end

   function automatic longint unsigned exp_neg_q30(longint unsigned u);
      longint unsigned w, k, y, r;
      if (u >= (64'd64 << 16)) return 0;
      w = (u * 64'd94548) >> 16;
      k = w >> 16;
      if (k > 30) return 0;
      y = ((w & 64'hFFFF) * 64'd744261118) >> 16;
      r = 64'd1 << 30;
      for (int i = 9; i >= 1; i--) begin
         r = (64'd1 << 30) - ((y * r) >> 30) / longint'(i);
      end
      return r >> k;
   endfunction

   function automatic longint unsigned ln1p_q30(longint unsigned z);
      longint unsigned m, mant, f, q, q2, pw, acc;
      int p;
      m = 64'd65536 + z;
      p = 0;
      while (p < 63 && (m >> (p + 1)) != 0) p++;
      if (p >= 30) mant = m >> (p - 30);
      else mant = m << (30 - p);
      f = mant - (64'd1 << 30);
      q = (f << 30) / (mant + (64'd1 << 30));
      q2 = (q * q) >> 30;
      acc = q;
      pw = q;
      for (int k = 3; k <= 11; k += 2) begin
         pw = (pw * q2) >> 30;
         acc += pw / longint'(k);
      end
      return longint'(p - 16) * 64'd744261118 + 2 * acc;
   endfunction

   function automatic longint unsigned peak_shape(longint unsigned tmag);
      if (tmag >= (64'd12 << 16)) return 0;
      return exp_neg_q30((tmag * tmag) >> 17);
   endfunction

   function automatic longint distance_q16(int x, int mean, int sigma);
      int d;
      longint unsigned q;
      d = x - mean;
      if (sigma == 0) sigma = 1;
      q = (longint'(d < 0 ? -d : d) << 16) / longint'(sigma);
      return d < 0 ? -longint'(q) : longint'(q);
   endfunction

   function automatic logic [22:0] curve_at(gpcb_pkg::cfg_type c, logic signed [15:0] x);
      int alpha;
      longint unsigned a, n, g, cb, s, z, u, total;
      longint tg, tc, a16;
      alpha = c.cb_tail_start;
      a = longint'(alpha < 0 ? -alpha : alpha);
      n = (c.cb_tail_power != 0) ? longint'(c.cb_tail_power) : 1;
      if (a == 0) a = 1;
      a16 = longint'(a << 4);
      tg = distance_q16(x, c.gauss_center, int'(c.gauss_width));
      g = peak_shape(tg < 0 ? -tg : tg);
      tc = distance_q16(x, c.cb_center, int'(c.cb_width));
      if (alpha < 0) tc = -tc;
      if (tc >= -a16) begin
         cb = peak_shape(tc < 0 ? -tc : tc);
      end else begin
         s = -a16 - tc;
         z = (a * s) / n;
         u = ((a * a) >> 9) + ((n * ln1p_q30(z)) >> 26);
         cb = exp_neg_q30(u);
      end
      total = (longint'(c.gauss_amplitude) * g + longint'(c.cb_amplitude) * cb) >> 24;
      if (total > 64'd8388607) total = 64'd8388607;
      return total[22:0];
   endfunction

   task automatic report_mismatch(input string what);
      $display("mismatch: %s", what);
      mismatch_count++;
   endtask

   // Drives the request side and records the expected word for every accepted sample.
   always @(posedge clock) begin
      if (req_valid && !req_stall) expected_curve.push_back(curve_at(model_cfg, req_x_value));
      if (!reset && !(req_valid && req_stall)) begin
         if (x_backlog.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
            req_valid <= 1'b1;
            req_x_value <= x_backlog.pop_front();
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin
      logic [22:0] want;
      if (rsp_valid && !rsp_stall) begin
         if (expected_curve.size() == 0) begin
            report_mismatch($sformatf("unexpected word %0d", rsp_curve_value));
         end else begin
            want = expected_curve.pop_front();
            if (rsp_curve_value !== want)
               report_mismatch($sformatf("curve_value %0d, expected %0d",
                                         rsp_curve_value, want));
         end
      end
      rsp_stall <= !reset && ($urandom_range(0, 99) < recv_stall_pct);
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CycleLimit) begin
         $display("tb_gauss_plus_crystal_ball_eval_core failed");
         $finish;
      end
   end

   task automatic write_reg(input logic [gpcb_pkg::CsrIndexWidth-1:0] idx,
                            input logic [15:0] data);
      @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_index <= idx;
      csr_write_data <= data;
      case (idx)
         gpcb_pkg::RegGaussAmplitude: model_cfg.gauss_amplitude = data;
         gpcb_pkg::RegGaussCenter:    model_cfg.gauss_center = data;
         gpcb_pkg::RegGaussWidth:     model_cfg.gauss_width = data[14:0];
         gpcb_pkg::RegCbAmplitude:    model_cfg.cb_amplitude = data;
         gpcb_pkg::RegCbCenter:       model_cfg.cb_center = data;
         gpcb_pkg::RegCbWidth:        model_cfg.cb_width = data[14:0];
         gpcb_pkg::RegCbTailStart:    model_cfg.cb_tail_start = data;
         gpcb_pkg::RegCbTailPower:    model_cfg.cb_tail_power = data[14:0];
         default:                     model_cfg = model_cfg;
      endcase
      @(posedge clock);
      csr_write_enable <= 1'b0;
   endtask

   task automatic load_cfg(input gpcb_pkg::cfg_type c);
      write_reg(gpcb_pkg::RegGaussAmplitude, c.gauss_amplitude);
      write_reg(gpcb_pkg::RegGaussCenter, c.gauss_center);
      write_reg(gpcb_pkg::RegGaussWidth, {1'b0, c.gauss_width});
      write_reg(gpcb_pkg::RegCbAmplitude, c.cb_amplitude);
      write_reg(gpcb_pkg::RegCbCenter, c.cb_center);
      write_reg(gpcb_pkg::RegCbWidth, {1'b0, c.cb_width});
      write_reg(gpcb_pkg::RegCbTailStart, c.cb_tail_start);
      write_reg(gpcb_pkg::RegCbTailPower, {1'b0, c.cb_tail_power});
   endtask

   function automatic logic [15:0] pick16(logic [15:0] lo, logic [15:0] hi);
      case ($urandom_range(0, 9))
         0: return lo;
         1: return hi;
         default: return 16'($urandom_range(0, 65535));
      endcase
   endfunction

   function automatic logic [14:0] pick_width();
      case ($urandom_range(0, 9))
         0: return 15'd1;
         1: return 15'h7FFF;
         2: return 15'd0;
         3, 4, 5: return 15'($urandom_range(1, 32767));
         default: return 15'($urandom_range(200, 4000));
      endcase
   endfunction

   function automatic logic signed [15:0] sample_near(int centre, int width);
      int span, v;
      span = width * 8 + 1;
      v = centre + int'($urandom_range(0, 2 * span)) - span;
      if (v < -32768) v = -32768;
      if (v > 32767) v = 32767;
      return 16'(v);
   endfunction

   task automatic wait_idle();
      while (x_backlog.size() > 0 || req_valid || expected_curve.size() > 0)
         @(posedge clock);
      repeat (DrainCycles) @(posedge clock);
   endtask

   task automatic set_mode(input int phase);
      case (phase % 4)
         0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
         1: begin send_idle_pct = 67; recv_stall_pct = 0;  end
         2: begin send_idle_pct = 0;  recv_stall_pct = 67; end
         default: begin send_idle_pct = 23; recv_stall_pct = 23; end
      endcase
   endtask

   initial begin
      gpcb_pkg::cfg_type c;
      logic signed [15:0] fixed_x[8];
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      for (int phase = 0; phase < 3; phase++) begin
         set_mode(phase);
         if (phase == 1) begin
            c = '{gauss_amplitude: 16'hFFFF, gauss_center: 16'sd0, gauss_width: 15'd0,
                  cb_amplitude: 16'hFFFF, cb_center: 16'sd0, cb_width: 15'd0,
                  cb_tail_start: 16'sd0, cb_tail_power: 15'd0};
            load_cfg(c);
         end else if (phase == 2) begin
            c = '{gauss_amplitude: 16'd0, gauss_center: -16'sd32768, gauss_width: 15'h7FFF,
                  cb_amplitude: 16'hFFFF, cb_center: 16'sd32767, cb_width: 15'h7FFF,
                  cb_tail_start: -16'sd32768, cb_tail_power: 15'h7FFF};
            load_cfg(c);
         end
         fixed_x = '{-16'sd32768, 16'sd32767, 16'sd0, 16'sd1, -16'sd1,
                     model_cfg.gauss_center, model_cfg.cb_center,
                     model_cfg.cb_center - 16'sd4096};
         foreach (fixed_x[i]) x_backlog.push_back(fixed_x[i]);
         wait_idle();
      end

      for (int phase = 3; phase < 11; phase++) begin
         set_mode(phase);
         c.gauss_amplitude = pick16(16'd0, 16'hFFFF);
         c.gauss_center = pick16(16'h8000, 16'h7FFF);
         c.gauss_width = pick_width();
         c.cb_amplitude = pick16(16'd0, 16'hFFFF);
         c.cb_center = $signed(16'($urandom_range(0, 65535))) >>> 1;
         c.cb_width = pick_width();
         case ($urandom_range(0, 7))
            0: c.cb_tail_start = 16'sd0;
            1: c.cb_tail_start = -16'sd32768;
            2: c.cb_tail_start = 16'sd32767;
            default: c.cb_tail_start = 16'($signed(16'($urandom_range(0, 16383)))
                                           * ($urandom_range(0, 1) ? 1 : -1));
         endcase
         case ($urandom_range(0, 7))
            0: c.cb_tail_power = 15'd0;
            1: c.cb_tail_power = 15'd1;
            2: c.cb_tail_power = 15'h7FFF;
            default: c.cb_tail_power = 15'($urandom_range(2048, 24576));
         endcase
         load_cfg(c);
         for (int i = 0; i < 60; i++) begin
            case ($urandom_range(0, 2))
               0: x_backlog.push_back(16'($urandom_range(0, 65535)));
               1: x_backlog.push_back(sample_near(model_cfg.cb_center,
                                                  int'(model_cfg.cb_width)));
               default: x_backlog.push_back(sample_near(model_cfg.gauss_center,
                                                        int'(model_cfg.gauss_width)));
            endcase
         end
         wait_idle();
      end

      if (mismatch_count == 0) begin
         $display("tb_gauss_plus_crystal_ball_eval_core passed");
      end else begin
         $display("tb_gauss_plus_crystal_ball_eval_core failed");
      end
      $finish;
   end

endmodule
